// File: rtl/tnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tnf_pkg;

  // configuration port
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned MODE_W       = 9;
  localparam int unsigned LEN_W        = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'b1;
  localparam logic [MODE_W-1:0]    MODE_RESET     = 9'h000;
  localparam logic [LEN_W-1:0]     MAX_LEN_RESET  = 16'hFFFF;

  // mode flag bits
  localparam int unsigned MB_STRIP    = 0;
  localparam int unsigned MB_DROP_WS  = 1;
  localparam int unsigned MB_DROP_CTL = 2;
  localparam int unsigned MB_LEAD     = 3;
  localparam int unsigned MB_COLLAPSE = 4;
  localparam int unsigned MB_UPPER    = 5;
  localparam int unsigned MB_BRACKET  = 6;
  localparam int unsigned MB_TRAIL    = 7;
  localparam int unsigned MB_QUOTE    = 8;

  // characters
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_RBRACK   = 8'h5D;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_LOW_Z    = 8'h7A;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] PARITY_MASK = 8'h7F;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int unsigned NUM_QT    = 6;
  localparam int unsigned OPQ_DEPTH = 4;

  typedef enum logic [1:0] {
    QT_NONE   = 2'd0,
    QT_SINGLE = 2'd1,
    QT_DOUBLE = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    OP_DROP = 2'd0,
    OP_END  = 2'd1,
    OP_HOLD = 2'd2,
    OP_EMIT = 2'd3
  } op_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       run_overflow;
  } out_item_t;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] ch;
    logic       last;
  } op_t;

endpackage

`default_nettype wire

// File: rtl/tnf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tnf_front import tnf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic              accept_i,
  input  wire in_item_t          item_i,
  output op_t                    op_o
);

  quote_e qt_q [NUM_QT];
  quote_e qt_d [NUM_QT];
  logic   lead_q, lead_d;
  logic   run_q, run_d;
  logic   ended_q, ended_d;

  logic [7:0] c;
  logic       keep;
  logic       term;
  logic       qd;
  logic [2:0] qr;

  function automatic logic [2:0] quote_eval(input quote_e st, input logic [7:0] ch);
    logic   q;
    quote_e nx;
    q  = 1'b0;
    nx = st;
    case (st)
      QT_SINGLE: begin
        q = 1'b1;
        if (ch == CH_SQUOTE) nx = QT_NONE;
      end
      QT_DOUBLE: begin
        q = 1'b1;
        if (ch == CH_DQUOTE) nx = QT_NONE;
      end
      default: begin
        if (ch == CH_SQUOTE) begin
          q  = 1'b1;
          nx = QT_SINGLE;
        end else if (ch == CH_DQUOTE) begin
          q  = 1'b1;
          nx = QT_DOUBLE;
        end
      end
    endcase
    return {q, nx};
  endfunction

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_QT; i++) qt_d[i] = qt_q[i];
    lead_d  = lead_q;
    run_d   = run_q;
    ended_d = ended_q;
    c       = item_i.in_byte;
    keep    = 1'b1;
    term    = 1'b0;
    qd      = 1'b0;
    qr      = '0;

    if (ended_q || (c == CH_NUL)) begin
      term = 1'b1;
      keep = 1'b0;
    end

    if (keep && mode_i[MB_STRIP]) begin
      qr = quote_eval(qt_q[0], c);
      if (mode_i[MB_QUOTE]) qt_d[0] = quote_e'(qr[1:0]);
      c = c & PARITY_MASK;
      if (c == CH_NUL) begin
        term = 1'b1;
        keep = 1'b0;
      end
    end

    if (keep && mode_i[MB_DROP_WS]) begin
      qr = quote_eval(qt_q[1], c);
      if (mode_i[MB_QUOTE]) qt_d[1] = quote_e'(qr[1:0]);
      qd = mode_i[MB_QUOTE] & qr[2];
      if (!qd && is_ws(c)) keep = 1'b0;
    end

    if (keep && mode_i[MB_DROP_CTL]) begin
      qr = quote_eval(qt_q[2], c);
      if (mode_i[MB_QUOTE]) qt_d[2] = quote_e'(qr[1:0]);
      qd = mode_i[MB_QUOTE] & qr[2];
      if (!qd) begin
        if (c == CH_TAB) c = CH_SPACE;
        else if ((c < CH_SPACE) || (c == CH_DEL)) keep = 1'b0;
      end
    end

    if (keep && mode_i[MB_LEAD] && !lead_q) begin
      if (is_ws(c)) keep = 1'b0;
      else lead_d = 1'b1;
    end

    if (keep && mode_i[MB_COLLAPSE]) begin
      qr = quote_eval(qt_q[3], c);
      if (mode_i[MB_QUOTE]) qt_d[3] = quote_e'(qr[1:0]);
      qd = mode_i[MB_QUOTE] & qr[2];
      if (!qd) begin
        if (is_ws(c)) begin
          if (run_q) begin
            keep = 1'b0;
          end else begin
            c     = CH_SPACE;
            run_d = 1'b1;
          end
        end else begin
          run_d = 1'b0;
        end
      end
    end

    if (keep && mode_i[MB_UPPER]) begin
      qr = quote_eval(qt_q[4], c);
      if (mode_i[MB_QUOTE]) qt_d[4] = quote_e'(qr[1:0]);
      qd = mode_i[MB_QUOTE] & qr[2];
      if (!qd && (c >= CH_LOW_A) && (c <= CH_LOW_Z)) c = c - CASE_OFFSET;
    end

    if (keep && mode_i[MB_BRACKET]) begin
      qr = quote_eval(qt_q[5], c);
      if (mode_i[MB_QUOTE]) qt_d[5] = quote_e'(qr[1:0]);
      qd = mode_i[MB_QUOTE] & qr[2];
      if (!qd) begin
        if (c == CH_LBRACK) c = CH_LPAREN;
        else if (c == CH_RBRACK) c = CH_RPAREN;
      end
    end

    if (term) ended_d = 1'b1;

    op_o.ch   = c;
    op_o.last = item_i.in_last;
    if (term) op_o.kind = OP_END;
    else if (!keep) op_o.kind = OP_DROP;
    else if (mode_i[MB_TRAIL] && is_ws(c)) op_o.kind = OP_HOLD;
    else op_o.kind = OP_EMIT;

    // string done: back to start-of-string state
    if (item_i.in_last) begin
      for (int i = 0; i < NUM_QT; i++) qt_d[i] = QT_NONE;
      lead_d  = 1'b0;
      run_d   = 1'b0;
      ended_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QT; i++) qt_q[i] <= QT_NONE;
      lead_q  <= 1'b0;
      run_q   <= 1'b0;
      ended_q <= 1'b0;
    end else if (accept_i) begin
      for (int i = 0; i < NUM_QT; i++) qt_q[i] <= qt_d[i];
      lead_q  <= lead_d;
      run_q   <= run_d;
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tnf_opq.sv
`timescale 1ns / 1ps
`default_nettype none

module tnf_opq import tnf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       op_o
);

  localparam int unsigned PTR_W = $clog2(OPQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OPQ_DEPTH + 1);

  op_t              mem_q [OPQ_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(OPQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? PTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_i;
  end

endmodule

`default_nettype wire

// File: rtl/tnf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tnf_back import tnf_pkg::*; #(
  parameter int unsigned WS_HOLD_DEPTH = 63
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [LEN_W-1:0] max_len_i,
  input  wire logic             op_valid_i,
  input  wire op_t              op_i,
  output logic                  op_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output out_item_t             result_o
);

  localparam int unsigned CNT_W = $clog2(WS_HOLD_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(WS_HOLD_DEPTH);

  logic [WS_HOLD_DEPTH-1:0] hold_q, hold_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [LEN_W-1:0]         ecnt_q, ecnt_d;
  logic                     any_q, any_d;
  logic                     ovld_q, ovld_d;
  out_item_t                res_q, res_d;

  logic       can_out;
  logic       allowed;
  logic       final_ok;
  logic       done;
  logic       load;
  logic [7:0] head_ch;
  logic       in_tab;

  assign empty_o  = !ovld_q;
  assign result_o = res_q;
  assign op_pop_o = done;

  assign can_out  = !ovld_q || pop_i;
  assign allowed  = ecnt_q < max_len_i;
  // this character reaches the limit; nothing after it gets out
  assign final_ok = ({1'b0, ecnt_q} + 1'b1) >= {1'b0, max_len_i};
  assign head_ch  = hold_q[0] ? CH_TAB : CH_SPACE;
  assign in_tab   = (op_i.ch == CH_TAB);

  always_comb begin
    hold_d = hold_q;
    cnt_d  = cnt_q;
    ecnt_d = ecnt_q;
    any_d  = any_q;
    done   = 1'b0;
    load   = 1'b0;
    res_d  = '{out_byte: CH_NUL, out_valid: 1'b0, out_last: 1'b1, run_overflow: 1'b0};

    if (op_valid_i) begin
      case (op_i.kind)
        OP_HOLD: begin
          if ((cnt_q == CNT_W'(WS_HOLD_DEPTH)) && allowed) begin
            // buffer full: oldest goes out early
            if (can_out) begin
              load  = 1'b1;
              res_d = '{out_byte: head_ch, out_valid: 1'b1, out_last: op_i.last,
                        run_overflow: 1'b1};
              ecnt_d = ecnt_q + 1'b1;
              hold_d = hold_q >> 1;
              hold_d[WS_HOLD_DEPTH-1] = in_tab;
              done   = 1'b1;
            end
          end else if (op_i.last) begin
            if (can_out) begin
              load = 1'b1;
              done = 1'b1;
            end
          end else begin
            if (cnt_q == CNT_W'(WS_HOLD_DEPTH)) begin
              hold_d = hold_q >> 1;
              hold_d[WS_HOLD_DEPTH-1] = in_tab;
            end else begin
              hold_d[cnt_q[IDX_W-1:0]] = in_tab;
              cnt_d = cnt_q + 1'b1;
            end
            done = 1'b1;
          end
        end
        OP_EMIT: begin
          if ((cnt_q != '0) && allowed) begin
            // flush held run, one character a cycle while the result slot is free
            if (can_out) begin
              load  = 1'b1;
              res_d = '{out_byte: head_ch, out_valid: 1'b1,
                        out_last: op_i.last && final_ok, run_overflow: 1'b0};
              ecnt_d = ecnt_q + 1'b1;
              any_d  = 1'b1;
              hold_d = hold_q >> 1;
              cnt_d  = cnt_q - 1'b1;
            end
          end else if (allowed) begin
            if (can_out) begin
              load  = 1'b1;
              res_d = '{out_byte: op_i.ch, out_valid: 1'b1, out_last: op_i.last,
                        run_overflow: 1'b0};
              ecnt_d = ecnt_q + 1'b1;
              cnt_d  = '0;
              done   = 1'b1;
            end
          end else if (op_i.last && !any_q) begin
            if (can_out) begin
              load  = 1'b1;
              cnt_d = '0;
              done  = 1'b1;
            end
          end else begin
            cnt_d = '0;
            done  = 1'b1;
          end
        end
        default: begin
          // drop or end of string
          if (!op_i.last) begin
            if (op_i.kind == OP_END) cnt_d = '0;
            done = 1'b1;
          end else if (can_out) begin
            load = 1'b1;
            done = 1'b1;
          end
        end
      endcase
    end

    if (done) begin
      any_d = 1'b0;
      if (op_i.last) begin
        cnt_d  = '0;
        ecnt_d = '0;
      end
    end

    ovld_d = load ? 1'b1 : (pop_i ? 1'b0 : ovld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ecnt_q <= '0;
      any_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ecnt_q <= ecnt_d;
      any_q  <= any_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (load) res_q <= res_d;
  end

endmodule

`default_nettype wire

// File: rtl/text_normalize_filter_core.sv
// Channel   Dir  Handshake           Payload
// input     in   push_i / full_o     item_i   (in_item_t)
// result    out  pop_i / empty_o     result_o (out_item_t)
// config    in   cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// The front end classifies one item per cycle, while full_o is low, into a
// four-entry op queue. The back end emits one result per cycle while its
// result slot is free; an item ending a held whitespace run follows the
// held characters. full_o rises only when the op queue fills behind such a
// flush or a stalled result. Reset clears all per-string state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module text_normalize_filter_core import tnf_pkg::*; #(
  parameter int unsigned WS_HOLD_DEPTH = 63
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire in_item_t              item_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output out_item_t                  result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [MODE_W-1:0] mode_q;
  logic [LEN_W-1:0]  max_len_q;

  logic accept;
  op_t  fe_op;
  logic opq_valid;
  op_t  opq_op;
  logic opq_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RESET;
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE_FLAGS: mode_q    <= cfg_wdata_i[MODE_W-1:0];
        CFG_MAX_LEN:    max_len_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push_i && !full_o;

  tnf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (mode_q),
    .accept_i (accept),
    .item_i   (item_i),
    .op_o     (fe_op)
  );

  tnf_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .op_i    (fe_op),
    .full_o  (full_o),
    .pop_i   (opq_pop),
    .valid_o (opq_valid),
    .op_o    (opq_op)
  );

  tnf_back #(
    .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_len_i  (max_len_q),
    .op_valid_i (opq_valid),
    .op_i       (opq_op),
    .op_pop_o   (opq_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .result_o   (result_o)
  );

`ifndef SYNTHESIS
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !result_o.out_valid) |-> result_o.out_last)
    else $error("bare end marker without out_last");

  a_ovf_is_ws: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.run_overflow) |->
      (result_o.out_valid && (result_o.out_byte == CH_SPACE || result_o.out_byte == CH_TAB)))
    else $error("overflow flag on a non-whitespace result");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.out_valid && $stable(max_len_q) && !$past(cfg_we_i))
      |-> (max_len_q != '0))
    else $error("character emitted with max_len of zero");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tnf_pkg::*;

  localparam int unsigned WS_HOLD_DEPTH = 63;
  localparam logic [MODE_W-1:0] MODE_ALL = '1;
  // passes that leave a whitespace run intact for the trailing hold
  localparam logic [MODE_W-1:0] RUN_KEEP = MODE_W'((1 << MB_STRIP) | (1 << MB_DROP_CTL) |
                                                   (1 << MB_UPPER) | (1 << MB_BRACKET) |
                                                   (1 << MB_QUOTE));
  localparam logic [MODE_W-1:0] RUN_TRAIL = MODE_W'(1 << MB_TRAIL);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push_i = 1'b0;
  logic                  pop_i = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  in_item_t              item_i = '0;
  logic                  full_o;
  logic                  empty_o;
  out_item_t             result_o;

  text_normalize_filter_core #(
    .WS_HOLD_DEPTH(WS_HOLD_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .item_i     (item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // predictor state
  logic [MODE_W-1:0] mode_q;
  logic [LEN_W-1:0]  len_cap;
  quote_e            qt [NUM_QT];
  bit                lead_done;
  bit                run_seen;
  bit                str_ended;
  bit                held_tab [WS_HOLD_DEPTH];
  int                held_cnt;
  int                emit_cnt;

  out_item_t step_chars[$];
  out_item_t want_chars[$];
  int        errors = 0;
  int        n_results = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  bit        steady = 1'b0;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } dir_row_t;

  dir_row_t dir_rows [31] = '{
    // reset config: every byte but NUL passes through
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h61, 1'b0}, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h09, 1'b1}, 1'b1, '{8'h09, 1'b1, 1'b1, 1'b0}},
    // all passes with quote mode
    '{ROW_CFG,  CFG_MODE_FLAGS, 16'h01FF, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h20, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h27, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h61, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h5B, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h27, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h62, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h5D, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'hE2, 1'b0}, 1'b0, '0},
    // parity strip turns this one into a terminator
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h80, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h63, 1'b1}, 1'b0, '0},
    // leading, collapse, trailing, quotes; cut at three characters
    '{ROW_CFG,  CFG_MODE_FLAGS, 16'h0198, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_CFG,  CFG_MAX_LEN,    16'h0003, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h09, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h78, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h09, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h20, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h22, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h20, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h79, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h20, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h09, 1'b1}, 1'b0, '0},
    // zero length: only the bare end marker comes out
    '{ROW_CFG,  CFG_MODE_FLAGS, 16'h0004, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_CFG,  CFG_MAX_LEN,    16'h0000, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h01, 1'b0}, 1'b0, '0},
    '{ROW_ITEM, CFG_MODE_FLAGS, 16'h0000, '{8'h71, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG,  CFG_MAX_LEN,    16'hFFFF, '{8'h00, 1'b0}, 1'b0, '0}
  };

  function automatic bit is_ws(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // advance one pass's quote tracker; 1 when c belongs to quoted text
  function automatic bit in_quote(int slot, logic [7:0] c);
    if (!mode_q[MB_QUOTE]) return 1'b0;
    if (qt[slot] != QT_NONE) begin
      if ((qt[slot] == QT_SINGLE && c == CH_SQUOTE) || (qt[slot] == QT_DOUBLE && c == CH_DQUOTE))
        qt[slot] = QT_NONE;
      return 1'b1;
    end
    if (c == CH_SQUOTE) begin
      qt[slot] = QT_SINGLE;
      return 1'b1;
    end
    if (c == CH_DQUOTE) begin
      qt[slot] = QT_DOUBLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void put_char(logic [7:0] c, bit ov);
    out_item_t r;
    if (emit_cnt >= len_cap) return;
    r.out_byte = c;
    r.out_valid = 1'b1;
    r.out_last = 1'b0;
    r.run_overflow = ov;
    step_chars.push_back(r);
    emit_cnt++;
  endfunction

  function automatic void clear_string();
    foreach (qt[i]) qt[i] = QT_NONE;
    lead_done = 1'b0;
    run_seen = 1'b0;
    str_ended = 1'b0;
    held_cnt = 0;
    emit_cnt = 0;
  endfunction

  // run one byte through the enabled passes, leaving its results in step_chars
  function automatic void filter_char(in_item_t it);
    logic [7:0] c;
    bit         keep;
    out_item_t  r;
    c = it.in_byte;
    keep = 1'b1;
    step_chars.delete();
    if (str_ended || c == CH_NUL) begin
      str_ended = 1'b1;
      held_cnt = 0;
      keep = 1'b0;
    end
    if (keep && mode_q[MB_STRIP]) begin
      void'(in_quote(0, c));
      c = c & PARITY_MASK;
      if (c == CH_NUL) begin
        str_ended = 1'b1;
        held_cnt = 0;
        keep = 1'b0;
      end
    end
    if (keep && mode_q[MB_DROP_WS] && !in_quote(1, c) && is_ws(c)) keep = 1'b0;
    if (keep && mode_q[MB_DROP_CTL] && !in_quote(2, c)) begin
      if (c == CH_TAB) c = CH_SPACE;
      else if (c < CH_SPACE || c == CH_DEL) keep = 1'b0;
    end
    if (keep && mode_q[MB_LEAD] && !lead_done) begin
      if (is_ws(c)) keep = 1'b0;
      else lead_done = 1'b1;
    end
    if (keep && mode_q[MB_COLLAPSE] && !in_quote(3, c)) begin
      if (is_ws(c)) begin
        if (run_seen) keep = 1'b0;
        else begin
          c = CH_SPACE;
          run_seen = 1'b1;
        end
      end else begin
        run_seen = 1'b0;
      end
    end
    if (keep && mode_q[MB_UPPER] && !in_quote(4, c) && c >= CH_LOW_A && c <= CH_LOW_Z)
      c = c - CASE_OFFSET;
    if (keep && mode_q[MB_BRACKET] && !in_quote(5, c)) begin
      if (c == CH_LBRACK) c = CH_LPAREN;
      else if (c == CH_RBRACK) c = CH_RPAREN;
    end
    if (keep) begin
      if (mode_q[MB_TRAIL] && is_ws(c)) begin
        // hold buffer full: push the oldest one out early
        if (held_cnt >= WS_HOLD_DEPTH) begin
          put_char(held_tab[0] ? CH_TAB : CH_SPACE, 1'b1);
          for (int i = 0; i < WS_HOLD_DEPTH - 1; i++) held_tab[i] = held_tab[i + 1];
          held_cnt = WS_HOLD_DEPTH - 1;
        end
        held_tab[held_cnt] = (c == CH_TAB);
        held_cnt++;
      end else begin
        for (int i = 0; i < held_cnt; i++) put_char(held_tab[i] ? CH_TAB : CH_SPACE, 1'b0);
        held_cnt = 0;
        put_char(c, 1'b0);
      end
    end
    if (it.in_last) begin
      if (step_chars.size() > 0) begin
        r = step_chars.pop_back();
        r.out_last = 1'b1;
      end else begin
        r = '0;
        r.out_last = 1'b1;
      end
      step_chars.push_back(r);
      clear_string();
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: result %0d %s got %0h want %0h", $time, n_results, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // sender bursts with random gaps, unless the phase runs steady
  task automatic pace();
    if (!steady && burst_left <= 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    push_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full_o);
    filter_char(it);
    if (typed) want_chars.push_back(want);
    else foreach (step_chars[i]) want_chars.push_back(step_chars[i]);
    items_sent++;
    pace();
  endtask

  // hold the sender until every result is out and the op queue has drained
  task automatic wait_drained();
    push_i <= 1'b0;
    while (want_chars.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_MODE_FLAGS) mode_q = data[MODE_W-1:0];
    else len_cap = data[LEN_W-1:0];
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'($urandom_range(8'h41, 8'h7A));
    if (r < 48) return r[0] ? CH_TAB : CH_SPACE;
    if (r < 56) return r[0] ? CH_SQUOTE : CH_DQUOTE;
    if (r < 64) return r[0] ? CH_LBRACK : CH_RBRACK;
    if (r < 72) return r[0] ? CH_DEL : 8'($urandom_range(1, 31));
    if (r < 84) return 8'($urandom_range(128, 255));
    if (r < 86) return CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_string(int len, bit noisy);
    in_item_t it;
    for (int k = 0; k < len; k++) begin
      it.in_byte = noisy ? 8'($urandom_range(0, 255)) : pick_char();
      it.in_last = (k == len - 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  // a whitespace run that may be long enough to overflow the hold buffer
  task automatic send_ws_run();
    in_item_t it;
    int       n;
    bit       end_on_ws;
    n = $urandom_range(60, 72);
    end_on_ws = 1'($urandom_range(0, 1));
    it.in_byte = 8'h61;
    it.in_last = 1'b0;
    send_item(it, 1'b0, '0);
    for (int k = 0; k < n; k++) begin
      it.in_byte = $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
      it.in_last = end_on_ws && (k == n - 1);
      send_item(it, 1'b0, '0);
    end
    if (!end_on_ws) begin
      it.in_byte = 8'h7A;
      it.in_last = 1'b1;
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin : rx
    out_item_t w;
    static int rx_mode = 0;
    static int rx_hold = 0;
    static int cyc = 0;
    if (rst_ni && pop_i && !empty_o) begin
      if (want_chars.size() == 0) begin
        report_mismatch("unexpected result", int'(result_o), 0);
      end else begin
        w = want_chars.pop_front();
        check_field("out_byte", int'(result_o.out_byte), int'(w.out_byte));
        check_field("out_valid", int'(result_o.out_valid), int'(w.out_valid));
        check_field("out_last", int'(result_o.out_last), int'(w.out_last));
        check_field("run_overflow", int'(result_o.run_overflow), int'(w.run_overflow));
      end
      n_results++;
    end
    cyc++;
    if (cyc % 97 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: pop_i <= 1'b1;
      1: pop_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
        end else begin
          pop_i <= !pop_i;
          rx_hold = pop_i ? $urandom_range(1, 12) : $urandom_range(0, 4);
        end
      end
    endcase
  end

  initial begin : stim
    int                phase;
    int                n_str;
    int                r;
    bit                long_phase;
    logic [MODE_W-1:0] m;
    logic [LEN_W-1:0]  l;
    mode_q = MODE_RESET;
    len_cap = MAX_LEN_RESET;
    clear_string();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    phase = 0;
    while (items_sent < 185) begin
      long_phase = (phase == 1 || phase == 6);
      m = MODE_W'($urandom_range(0, 511));
      if (long_phase) m = (m & RUN_KEEP) | RUN_TRAIL;
      else if (phase % 5 == 0) m = MODE_ALL;
      else if (phase % 5 == 3) m = '0;
      r = $urandom_range(0, 99);
      if (long_phase || r < 55) l = MAX_LEN_RESET;
      else if (r < 80) l = LEN_W'($urandom_range(1, 12));
      else if (r < 88) l = '0;
      else l = LEN_W'($urandom_range(0, 65535));
      write_reg(CFG_MODE_FLAGS, CFG_DATA_W'(m));
      write_reg(CFG_MAX_LEN, l);
      steady = ($urandom_range(0, 3) == 0);
      n_str = $urandom_range(2, 5);
      for (int s = 0; s < n_str; s++) begin
        if (long_phase && s == 0) send_ws_run();
        else send_string($urandom_range(1, 14), $urandom_range(0, 6) == 0);
        // let the output side run dry mid-phase now and then
        if (s == 0 && phase % 3 == 2) wait_drained();
      end
      phase++;
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
